// ===== src/cpm_pkg.sv =====
// ----------------------------------------------------------------------------
// cpm_pkg
// Shared types and constants of the clause polarity merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpm_pkg;

  // fixed field widths
  localparam int unsigned VAR_W = 16;
  localparam int unsigned IDX_W = 5;

  // target list of a load item
  typedef enum logic [1:0] {
    LST_APOS = 2'd0,
    LST_ANEG = 2'd1,
    LST_BPOS = 2'd2,
    LST_BNEG = 2'd3
  } list_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_NO_MERGE = 2'd0,
    STAT_MERGED   = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_e;

  // test sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RD,
    S_CMP,
    S_FIN_RD,
    S_FIN_CMP
  } scan_state_e;

  // request from the load side to the test sequencer
  typedef struct packed {
    logic start;
    logic ovf;
  } scan_cmd_t;

  // result of one test
  typedef struct packed {
    logic               valid;
    status_e            status;
    logic [VAR_W-1:0]   rvar;
    logic               neg;
    logic [IDX_W-1:0]   idx;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== src/cpm_list_mem.sv =====
// ----------------------------------------------------------------------------
// cpm_list_mem
// Element store of the four lists: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cpm_list_mem
  import cpm_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [VAR_W-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [VAR_W-1:0] rdata_a_o,
  output logic      [VAR_W-1:0] rdata_b_o
);

  logic [VAR_W-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // two read ports, data registered
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== src/cpm_scan.sv =====
// ----------------------------------------------------------------------------
// cpm_scan
// Test sequencer: walks list pairs with one shared equality comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module cpm_scan
  import cpm_pkg::*;
#(
  parameter int unsigned MAX_LITS = 16,
  parameter int unsigned IW       = 5,
  parameter int unsigned AW       = 6
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire scan_cmd_t             cmd_i,
  input  wire logic [3:0][IW-1:0]    cnt_i,
  input  wire logic [VAR_W-1:0]      rdata_a_i,
  input  wire logic [VAR_W-1:0]      rdata_b_i,
  output logic      [AW-1:0]         raddr_a_o,
  output logic      [AW-1:0]         raddr_b_o,
  output logic                       busy_o,
  output scan_res_t                  res_o
);

  localparam int unsigned CW = IW + 1;
  localparam logic [AW-1:0] MaxA = AW'(MAX_LITS);

  scan_state_e state_q, state_d;
  logic          pass_q, pass_d;
  logic          skip_q, skip_d;
  logic          dir_q, dir_d;
  logic [IW-1:0] i_q, i_d;
  logic [IW-1:0] at_q, at_d;
  logic [IW-1:0] x0_q, x0_d;
  logic [IW-1:0] x1_q, x1_d;

  list_e         lg, sh, fa_list, fb_list;
  logic [IW-1:0] fa_idx, fb_idx, n, at_fin, lg_idx;
  logic [CW-1:0] pa, na, pb, nb;
  logic          eq;
  logic [IW+IDX_W-1:0] idx_wide;

  function automatic logic [AW-1:0] addr_of(list_e l, logic [IW-1:0] idx);
    return AW'(l) * MaxA + AW'(idx);
  endfunction

  // list selection for the current pass and the final check
  always_comb begin
    if (dir_q) begin
      lg      = pass_q ? LST_ANEG : LST_BPOS;
      sh      = pass_q ? LST_BNEG : LST_APOS;
      fa_list = LST_ANEG;
      fa_idx  = x1_q;
      fb_list = LST_BPOS;
      fb_idx  = x0_q;
    end else begin
      lg      = pass_q ? LST_BNEG : LST_APOS;
      sh      = pass_q ? LST_ANEG : LST_BPOS;
      fa_list = LST_APOS;
      fa_idx  = x0_q;
      fb_list = LST_BNEG;
      fb_idx  = x1_q;
    end
  end

  assign n      = cnt_i[sh];
  assign lg_idx = IW'(i_q + IW'(skip_q));
  assign at_fin = skip_q ? at_q : i_q;
  assign eq     = (rdata_a_i == rdata_b_i);

  assign pa = CW'(cnt_i[LST_APOS]);
  assign na = CW'(cnt_i[LST_ANEG]);
  assign pb = CW'(cnt_i[LST_BPOS]);
  assign nb = CW'(cnt_i[LST_BNEG]);

  // removed index is reported in five bits
  assign idx_wide = {{IDX_W{1'b0}}, fa_idx};

  // read addresses
  always_comb begin
    if (state_q == S_FIN_RD) begin
      raddr_a_o = addr_of(fa_list, fa_idx);
      raddr_b_o = addr_of(fb_list, fb_idx);
    end else begin
      raddr_a_o = addr_of(lg, lg_idx);
      raddr_b_o = addr_of(sh, i_q);
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= 1'b0;
      skip_q  <= 1'b0;
      dir_q   <= 1'b0;
      i_q     <= '0;
      at_q    <= '0;
      x0_q    <= '0;
      x1_q    <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      skip_q  <= skip_d;
      dir_q   <= dir_d;
      i_q     <= i_d;
      at_q    <= at_d;
      x0_q    <= x0_d;
      x1_q    <= x1_d;
    end
  end

  // next state and result
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    skip_d  = skip_q;
    dir_d   = dir_q;
    i_d     = i_q;
    at_d    = at_q;
    x0_d    = x0_q;
    x1_d    = x1_q;
    res_o   = '0;
    res_o.status = STAT_NO_MERGE;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.start) begin
          state_d = S_DECIDE;
        end
      end

      // pick the polarity case from the list lengths
      S_DECIDE: begin
        pass_d = 1'b0;
        skip_d = 1'b0;
        i_d    = '0;
        priority if (cmd_i.ovf) begin
          res_o.valid  = 1'b1;
          res_o.status = STAT_OVERFLOW;
          state_d      = S_IDLE;
        end else if (pa + CW'(1) == pb && na == nb + CW'(1)) begin
          dir_d   = 1'b1;
          state_d = S_RD;
        end else if (pa == pb + CW'(1) && na + CW'(1) == nb) begin
          dir_d   = 1'b0;
          state_d = S_RD;
        end else begin
          res_o.valid = 1'b1;
          state_d     = S_IDLE;
        end
      end

      // present the next pair, or close the pass
      S_RD: begin
        if (i_q == n) begin
          if (!pass_q) begin
            x0_d   = at_fin;
            pass_d = 1'b1;
            skip_d = 1'b0;
            i_d    = '0;
          end else begin
            x1_d    = at_fin;
            state_d = S_FIN_RD;
          end
        end else begin
          state_d = S_CMP;
        end
      end

      // compare one pair; first mismatch marks the extra element
      S_CMP: begin
        priority if (eq) begin
          i_d     = IW'(i_q + IW'(1));
          state_d = S_RD;
        end else if (!skip_q) begin
          skip_d  = 1'b1;
          at_d    = i_q;
          state_d = S_RD;
        end else begin
          res_o.valid = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_FIN_RD: begin
        state_d = S_FIN_CMP;
      end

      // both extra elements must be the same variable
      S_FIN_CMP: begin
        res_o.valid = 1'b1;
        if (eq) begin
          res_o.status = STAT_MERGED;
          res_o.rvar   = rdata_a_i;
          res_o.neg    = dir_q;
          res_o.idx    = idx_wide[IDX_W-1:0];
        end
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/clause_polarity_merge.sv =====
// ----------------------------------------------------------------------------
// clause_polarity_merge
// Loads two clauses and tests whether they merge on one opposite variable.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken at a clock edge with start_i high and
//   busy_o low. Each item appends var_req_i to the list selected by op_i, or
//   sets the overflow flag if that list is full. An item with last_i high
//   also starts the merge test.
//   Result channel: done_o is high for one cycle with status_o,
//   removed_var_o, removed_from_neg_o and removed_index_o; it is produced
//   only for last items. The receiver cannot stall; done_o drops after that
//   cycle, and the other result outputs hold until the next result.
//   Timing: load items are taken one per cycle while busy_o is low. After a
//   last item busy_o is high while one sequencer walks the lists with a
//   single comparator over a two-read-port element memory, reading and then
//   comparing each pair; an overflow or a length mismatch skips the scan.
//   After the strobe all counts and the overflow flag are clear and a new
//   clause pair can be loaded; the strobe cycle itself may take an item.
//   Reset: clears counts, the overflow flag and the sequencer; the element
//   memory is not cleared, as only loaded entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module clause_polarity_merge
  import cpm_pkg::*;
#(
  parameter int unsigned MAX_LITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [1:0]       op_i,
  input  wire logic [VAR_W-1:0] var_req_i,
  input  wire logic             last_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [VAR_W-1:0]      removed_var_o,
  output logic                  removed_from_neg_o,
  output logic [IDX_W-1:0]      removed_index_o
);

  localparam int unsigned IW    = $clog2(MAX_LITS + 1);
  localparam int unsigned DEPTH = 4 * MAX_LITS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] MaxA = AW'(MAX_LITS);
  localparam logic [IW-1:0] MaxI = IW'(MAX_LITS);

  logic [3:0][IW-1:0] cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic               accept;
  logic               room;
  logic [IW-1:0]      cur_cnt;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr_a, raddr_b;
  logic [VAR_W-1:0]   rdata_a, rdata_b;
  logic               scan_busy;
  scan_cmd_t          cmd;
  scan_res_t          res;

  logic               done_q;
  logic [1:0]         status_q;
  logic [VAR_W-1:0]   rvar_q;
  logic               neg_q;
  logic [IDX_W-1:0]   idx_q;

  assign busy_o  = scan_busy;
  assign accept  = start_i & ~scan_busy;
  assign cur_cnt = cnt_q[op_i];
  assign room    = (cur_cnt < MaxI);
  assign we      = accept & room;
  assign waddr   = AW'(op_i) * MaxA + AW'(cur_cnt);

  // load counts and overflow flag
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (res.valid) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end else if (accept) begin
      if (room) begin
        cnt_d[op_i] = IW'(cur_cnt + IW'(1));
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  assign cmd.start = accept & last_i;
  assign cmd.ovf   = ovf_q;

  // element memory
  cpm_list_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (var_req_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // test sequencer
  cpm_scan #(
    .MAX_LITS (MAX_LITS),
    .IW       (IW),
    .AW       (AW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .cnt_i     (cnt_q),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .busy_o    (scan_busy),
    .res_o     (res)
  );

  // output register, strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res.valid;
    end
  end

  // output register, payload
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q <= res.status;
      rvar_q   <= res.rvar;
      neg_q    <= res.neg;
      idx_q    <= res.idx;
    end
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign removed_var_o      = rvar_q;
  assign removed_from_neg_o = neg_q;
  assign removed_index_o    = idx_q;

  // a last item always starts the test
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_i) |=> busy_o)
    else $error("test did not start after last item");

  // the strobe comes with the sequencer back in idle and lists cleared
  a_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy_o && cnt_q == '0 && !ovf_q))
    else $error("lists not cleared at result");

  // non-merge results carry zero fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STAT_MERGED) |->
      (removed_var_o == '0 && !removed_from_neg_o && removed_index_o == '0))
    else $error("non-merge result has nonzero fields");

  // the status code is never the unused one
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == STAT_NO_MERGE || status_o == STAT_MERGED ||
                status_o == STAT_OVERFLOW))
    else $error("bad status code");

endmodule

`default_nettype wire
